### rtl/stok_pkg.sv
package stok_pkg;

   localparam int POSITION_WIDTH = 16;
   localparam int QUEUE_DEPTH    = 4;
   localparam int MAX_RESULTS    = 6;
   localparam int CNT_W          = $clog2(MAX_RESULTS + 1);
   localparam int IDX_W          = $clog2(MAX_RESULTS);

   // byte values the scanner cares about
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_N      = 8'h6E;

   // error codes; non-error results carry ERR_NONE
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_COMMENT   = 3'd0;
   localparam logic [2:0] ERR_ESCAPE    = 3'd1;
   localparam logic [2:0] ERR_UNCLOSED  = 3'd2;
   localparam logic [2:0] ERR_TAB       = 3'd3;
   localparam logic [2:0] ERR_REDUNDANT = 3'd4;
   localparam logic [2:0] ERR_SEPARATOR = 3'd5;

   typedef enum logic [3:0] {
      CLS_SPACE,
      CLS_TAB,
      CLS_CR,
      CLS_LF,
      CLS_SLASH,
      CLS_STAR,
      CLS_QUOTE,
      CLS_BSLASH,
      CLS_N,
      CLS_OTHER
   } cls_type;

   typedef struct packed {
      logic [7:0] text;
      cls_type    cls;
      logic       last;
   } item_type;

   typedef enum logic [2:0] {
      KIND_BYTE      = 3'd0,
      KIND_TOKEN_END = 3'd1,
      KIND_LINE_END  = 3'd2,
      KIND_ERROR     = 3'd3,
      KIND_DONE      = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_SCOMMENT,
      MODE_LCOMMENT,
      MODE_BARE,
      MODE_QUOTED,
      MODE_AFTER
   } mode_type;

   typedef enum logic [2:0] {
      HELD_NONE,
      HELD_CR,
      HELD_STAR,
      HELD_SLASH,
      HELD_QUOTE,
      HELD_BSLASH
   } held_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  token_byte;
      logic [15:0] line;
      logic [15:0] column;
      logic [2:0]  error_code;
   } res_type;

   typedef res_type [MAX_RESULTS-1:0] res_vec_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      res_vec_type      res;
   } bundle_type;

   typedef struct packed {
      logic       valid;
      bundle_type bundle;
   } hand_type;

endpackage

### rtl/stok_front.sv
module stok_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_text_byte,
   input  logic               req_end_of_text,
   output logic               out_valid,
   output stok_pkg::item_type out_item,
   input  logic               out_ready
);
   import stok_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   function automatic cls_type classify(logic [7:0] b);
      cls_type k;
      unique case (b)
         CH_SPACE:  k = CLS_SPACE;
         CH_TAB:    k = CLS_TAB;
         CH_CR:     k = CLS_CR;
         CH_LF:     k = CLS_LF;
         CH_SLASH:  k = CLS_SLASH;
         CH_STAR:   k = CLS_STAR;
         CH_QUOTE:  k = CLS_QUOTE;
         CH_BSLASH: k = CLS_BSLASH;
         CH_N:      k = CLS_N;
         default:   k = CLS_OTHER;
      endcase
      return k;
   endfunction

   assign req_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff && !out_ready;
      item_in  = item_ff;
      if (req_valid && req_ready) begin
         valid_in      = 1'b1;
         item_in.text  = req_text_byte;
         item_in.cls   = classify(req_text_byte);
         item_in.last  = req_end_of_text;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

### rtl/stok_fifo.sv
module stok_fifo #(
   parameter int DEPTH = stok_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  stok_pkg::item_type push_item,
   output logic               push_ready,
   output logic               pop_valid,
   output stok_pkg::item_type pop_item,
   input  logic               pop_ready
);
   import stok_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   item_type        mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] p);
      return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
   endfunction

   assign push_ready = count_ff != CntW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/stok_engine.sv
module stok_engine #(
   parameter int PW = stok_pkg::POSITION_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  stok_pkg::item_type item,
   output logic               item_pop,
   output stok_pkg::hand_type hand,
   input  logic               hand_ready
);
   import stok_pkg::*;

   localparam logic [PW-1:0] PosMax = '1;
   localparam logic [PW-1:0] PosOne = PW'(1);

   typedef struct packed {
      mode_type   mode;
      held_type   held;
      logic [PW-1:0] line;
      logic [PW-1:0] col;
      logic [PW-1:0] hl;
      logic [PW-1:0] hc;
      logic       has_tok;
      logic       err;
      bundle_type bun;
   } ctx_type;

   mode_type      mode_ff, mode_in;
   held_type      held_ff, held_in;
   logic [PW-1:0] line_ff, line_in;
   logic [PW-1:0] col_ff, col_in;
   logic [PW-1:0] hl_ff, hl_in;
   logic [PW-1:0] hc_ff, hc_in;
   logic          has_tok_ff, has_tok_in;
   logic          err_ff, err_in;

   // positions are reported in 16 bits whatever the counter width
   function automatic logic [15:0] pos16(logic [PW-1:0] p);
      logic [PW+15:0] wide;
      wide = {16'd0, p};
      return wide[15:0];
   endfunction

   function automatic ctx_type emit(ctx_type c, kind_type k, logic [7:0] b,
                                    logic [PW-1:0] l, logic [PW-1:0] col,
                                    logic [2:0] e);
      res_type r;
      r.kind       = k;
      r.token_byte = b;
      r.line       = pos16(l);
      r.column     = pos16(col);
      r.error_code = e;
      if (c.bun.count < CNT_W'(MAX_RESULTS)) begin
         c.bun.res[c.bun.count[IDX_W-1:0]] = r;
         c.bun.count = c.bun.count + CNT_W'(1);
      end
      return c;
   endfunction

   function automatic ctx_type take(ctx_type c);
      if (c.col != PosMax) c.col = c.col + PosOne;
      return c;
   endfunction

   function automatic ctx_type new_line(ctx_type c);
      if (c.has_tok) c = emit(c, KIND_LINE_END, '0, c.line, c.col, ERR_NONE);
      c.has_tok = 1'b0;
      if (c.line != PosMax) c.line = c.line + PosOne;
      c.col = PosOne;
      return c;
   endfunction

   function automatic ctx_type hold(ctx_type c, held_type h, logic keep_pos);
      c.held = h;
      if (!keep_pos) begin
         c.hl = c.line;
         c.hc = c.col;
      end
      return c;
   endfunction

   function automatic ctx_type fail(ctx_type c, logic [2:0] code,
                                    logic [PW-1:0] l, logic [PW-1:0] col);
      c      = emit(c, KIND_ERROR, '0, l, col, code);
      c.err  = 1'b1;
      c.held = HELD_NONE;
      return c;
   endfunction

   function automatic ctx_type token_end(ctx_type c, logic [PW-1:0] l,
                                         logic [PW-1:0] col);
      c         = emit(c, KIND_TOKEN_END, '0, l, col, ERR_NONE);
      c.has_tok = 1'b1;
      c.mode    = MODE_IDLE;
      return c;
   endfunction

   function automatic logic is_sep(cls_type k);
      return k == CLS_SPACE || k == CLS_TAB || k == CLS_CR || k == CLS_LF;
   endfunction

   function automatic ctx_type idle(ctx_type c, logic eos, cls_type k, logic [7:0] b);
      if (!eos) begin
         priority if (k == CLS_SPACE || k == CLS_TAB) begin
            c = take(c);
         end else if (k == CLS_CR) begin
            c = new_line(c);
            c = hold(c, HELD_CR, 1'b1);
         end else if (k == CLS_LF) begin
            c = new_line(c);
         end else if (k == CLS_SLASH) begin
            c = hold(c, HELD_SLASH, 1'b0);
            c = take(c);
         end else if (k == CLS_QUOTE) begin
            c      = take(c);
            c.mode = MODE_QUOTED;
         end else begin
            c      = emit(c, KIND_BYTE, b, c.line, c.col, ERR_NONE);
            c      = take(c);
            c.mode = MODE_BARE;
         end
      end
      return c;
   endfunction

   function automatic ctx_type process(ctx_type c, logic eos, cls_type k, logic [7:0] b);
      unique case (c.mode)
         MODE_IDLE: begin
            c = idle(c, eos, k, b);
         end
         MODE_SCOMMENT: begin
            if (!eos) begin
               if (k == CLS_CR || k == CLS_LF) begin
                  c.mode = MODE_IDLE;
                  c      = idle(c, eos, k, b);
               end else begin
                  c = take(c);
               end
            end
         end
         MODE_LCOMMENT: begin
            priority if (eos) begin
               c = fail(c, ERR_COMMENT, c.hl, c.hc);
            end else if (k == CLS_CR) begin
               c = new_line(c);
               c = hold(c, HELD_CR, 1'b1);
            end else if (k == CLS_LF) begin
               c = new_line(c);
            end else if (k == CLS_STAR) begin
               c = hold(c, HELD_STAR, 1'b1);
               c = take(c);
            end else begin
               c = take(c);
            end
         end
         MODE_BARE: begin
            priority if (eos) begin
               c = token_end(c, c.line, c.col);
            end else if (is_sep(k)) begin
               c = token_end(c, c.line, c.col);
               c = idle(c, eos, k, b);
            end else if (k == CLS_SLASH) begin
               c = hold(c, HELD_SLASH, 1'b0);
               c = take(c);
            end else begin
               c = emit(c, KIND_BYTE, b, c.line, c.col, ERR_NONE);
               c = take(c);
            end
         end
         MODE_QUOTED: begin
            priority if (eos) begin
               c = token_end(c, c.line, c.col);
            end else if (k == CLS_QUOTE) begin
               c = hold(c, HELD_QUOTE, 1'b0);
               c = take(c);
            end else if (k == CLS_BSLASH) begin
               c = hold(c, HELD_BSLASH, 1'b0);
               c = take(c);
            end else if (k == CLS_CR || k == CLS_LF) begin
               c = fail(c, ERR_UNCLOSED, c.line, c.col);
            end else if (k == CLS_TAB) begin
               c = fail(c, ERR_TAB, c.line, c.col);
            end else begin
               c = emit(c, KIND_BYTE, b, c.line, c.col, ERR_NONE);
               c = take(c);
            end
         end
         MODE_AFTER: begin
            priority if (eos) begin
               c = token_end(c, c.line, c.col);
            end else if (is_sep(k)) begin
               c = token_end(c, c.line, c.col);
               c = idle(c, eos, k, b);
            end else if (k == CLS_SLASH) begin
               c = hold(c, HELD_SLASH, 1'b0);
               c = take(c);
            end else if (k == CLS_QUOTE) begin
               c = fail(c, ERR_REDUNDANT, c.line, c.col);
            end else begin
               c = fail(c, ERR_SEPARATOR, c.line, c.col);
            end
         end
         default: begin
            c.mode = MODE_IDLE;
         end
      endcase
      return c;
   endfunction

   // resolve the held lookahead byte against this byte, then scan it
   function automatic ctx_type run(ctx_type c, logic eos, cls_type k, logic [7:0] b);
      held_type      h;
      logic [PW-1:0] hl;
      logic [PW-1:0] hc;
      logic          done;
      h      = c.held;
      hl     = c.hl;
      hc     = c.hc;
      done   = 1'b0;
      c.held = HELD_NONE;
      unique case (h)
         HELD_NONE: begin
            done = 1'b0;
         end
         HELD_CR: begin
            done = !eos && k == CLS_LF;
         end
         HELD_STAR: begin
            if (!eos && k == CLS_SLASH) begin
               c      = take(c);
               c.mode = MODE_IDLE;
               done   = 1'b1;
            end
         end
         HELD_SLASH: begin
            priority if (!eos && (k == CLS_SLASH || k == CLS_STAR)) begin
               if (c.mode != MODE_IDLE) c = token_end(c, hl, hc);
               c      = take(c);
               c.mode = (k == CLS_SLASH) ? MODE_SCOMMENT : MODE_LCOMMENT;
               done   = 1'b1;
            end else if (c.mode == MODE_AFTER) begin
               c    = fail(c, ERR_SEPARATOR, hl, hc);
               done = 1'b1;
            end else begin
               c      = emit(c, KIND_BYTE, CH_SLASH, hl, hc, ERR_NONE);
               c.mode = MODE_BARE;
            end
         end
         HELD_QUOTE: begin
            if (!eos && k == CLS_QUOTE) begin
               c    = emit(c, KIND_BYTE, CH_QUOTE, hl, hc, ERR_NONE);
               c    = take(c);
               done = 1'b1;
            end else begin
               c.mode = MODE_AFTER;
            end
         end
         HELD_BSLASH: begin
            priority if (!eos && k == CLS_N) begin
               c = emit(c, KIND_BYTE, CH_LF, hl, hc, ERR_NONE);
               c = take(c);
            end else if (!eos && k == CLS_QUOTE) begin
               c = emit(c, KIND_BYTE, CH_QUOTE, hl, hc, ERR_NONE);
               c = take(c);
            end else if (!eos && k == CLS_BSLASH) begin
               c = emit(c, KIND_BYTE, CH_BSLASH, hl, hc, ERR_NONE);
               c = take(c);
            end else begin
               c = fail(c, ERR_ESCAPE, hl, hc);
            end
            done = 1'b1;
         end
         default: begin
            done = 1'b0;
         end
      endcase
      if (!done) c = process(c, eos, k, b);
      return c;
   endfunction

   always_comb begin : step_blk
      ctx_type c;
      c.mode      = mode_ff;
      c.held      = held_ff;
      c.line      = line_ff;
      c.col       = col_ff;
      c.hl        = hl_ff;
      c.hc        = hc_ff;
      c.has_tok   = has_tok_ff;
      c.err       = err_ff;
      c.bun       = '0;
      if (!err_ff) begin
         c = run(c, 1'b0, item.cls, item.text);
         if (item.last && !c.err) begin
            c = run(c, 1'b1, item.cls, item.text);
            if (!c.err && c.has_tok) begin
               c         = emit(c, KIND_LINE_END, '0, c.line, c.col, ERR_NONE);
               c.has_tok = 1'b0;
            end
         end
      end
      if (item.last) begin
         c         = emit(c, KIND_DONE, '0, c.line, c.col, ERR_NONE);
         c.mode    = MODE_IDLE;
         c.held    = HELD_NONE;
         c.line    = PosOne;
         c.col     = PosOne;
         c.hl      = '0;
         c.hc      = '0;
         c.has_tok = 1'b0;
         c.err     = 1'b0;
      end

      // a byte with nothing to report never waits for the output stage
      item_pop    = item_valid && (hand_ready || (c.bun.count == '0));
      hand.valid  = item_pop && (c.bun.count != '0);
      hand.bundle = c.bun;

      mode_in    = item_pop ? c.mode    : mode_ff;
      held_in    = item_pop ? c.held    : held_ff;
      line_in    = item_pop ? c.line    : line_ff;
      col_in     = item_pop ? c.col     : col_ff;
      hl_in      = item_pop ? c.hl      : hl_ff;
      hc_in      = item_pop ? c.hc      : hc_ff;
      has_tok_in = item_pop ? c.has_tok : has_tok_ff;
      err_in     = item_pop ? c.err     : err_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         held_ff    <= HELD_NONE;
         line_ff    <= PosOne;
         col_ff     <= PosOne;
         hl_ff      <= '0;
         hc_ff      <= '0;
         has_tok_ff <= 1'b0;
         err_ff     <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         held_ff    <= held_in;
         line_ff    <= line_in;
         col_ff     <= col_in;
         hl_ff      <= hl_in;
         hc_ff      <= hc_in;
         has_tok_ff <= has_tok_in;
         err_ff     <= err_in;
      end
   end

endmodule

### rtl/stok_serial.sv
module stok_serial (
   input  logic               clock,
   input  logic               reset,
   input  stok_pkg::hand_type hand,
   output logic               hand_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_kind,
   output logic [7:0]         rsp_token_byte,
   output logic [15:0]        rsp_line_number,
   output logic [15:0]        rsp_column_number,
   output logic [2:0]         rsp_error_code,
   output logic               rsp_last_result
);
   import stok_pkg::*;

   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   bundle_type       bun_ff, bun_in;
   logic [CNT_W-1:0] next_pos;
   logic             is_last;
   res_type          cur;

   assign next_pos   = CNT_W'(idx_ff) + CNT_W'(1);
   assign is_last    = next_pos == bun_ff.count;
   assign hand_ready = !busy_ff || (rsp_ready && is_last);

   assign cur               = bun_ff.res[idx_ff];
   assign rsp_valid         = busy_ff;
   assign rsp_kind          = cur.kind;
   assign rsp_token_byte    = cur.token_byte;
   assign rsp_line_number   = cur.line;
   assign rsp_column_number = cur.column;
   assign rsp_error_code    = cur.error_code;
   assign rsp_last_result   = is_last;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      bun_in  = bun_ff;
      priority if (hand.valid && hand_ready) begin
         busy_in = 1'b1;
         idx_in  = '0;
         bun_in  = hand.bundle;
      end else if (busy_ff && rsp_ready) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      bun_ff <= bun_in;
   end

endmodule

### rtl/script_tokenizer.sv
// Path: an accepted byte is registered in the front, written into the queue, scanned,
//   and its bundle is loaded into the output register that drives rsp_valid.
// Throughput: one byte per cycle while rsp_ready is high and each byte yields
//   at most one result; a byte with more holds the single output register.
// Reset: synchronous, active high; clears scanner state, queue and output stage.
//   No clearing pass; req_ready is high as soon as reset is released.
module script_tokenizer #(
   parameter int POSITION_WIDTH = stok_pkg::POSITION_WIDTH,
   parameter int QUEUE_DEPTH    = stok_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_token_byte,
   output logic [15:0] rsp_line_number,
   output logic [15:0] rsp_column_number,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last_result
);
   import stok_pkg::*;

   // Front: registers each incoming transaction and tags the byte with its
   // class (separator, line break, slash, star, quote, backslash, 'n', other).
   logic     front_valid;
   item_type front_item;
   logic     front_ready;

   // Queue: decouples the front from the scanner so either side can stall.
   logic     q_valid;
   item_type q_item;
   logic     q_pop;

   // Scanner -> output stage: a bundle of up to six results per byte.
   hand_type hand;
   logic     hand_ready;

   stok_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .out_valid       (front_valid),
      .out_item        (front_item),
      .out_ready       (front_ready)
   );

   stok_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_item  (front_item),
      .push_ready (front_ready),
      .pop_valid  (q_valid),
      .pop_item   (q_item),
      .pop_ready  (q_pop)
   );

   // Scanner: mode, one held lookahead byte and the line/column counters.
   // A byte pops only when the output stage can take its bundle; bytes that
   // produce nothing (blanks, comment text) still pop one per cycle.
   stok_engine #(
      .PW (POSITION_WIDTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_valid),
      .item       (q_item),
      .item_pop   (q_pop),
      .hand       (hand),
      .hand_ready (hand_ready)
   );

   // Output stage: holds one bundle and hands out its results in order,
   // loading the next bundle in the same cycle the last result is taken.
   stok_serial u_serial (
      .clock             (clock),
      .reset             (reset),
      .hand              (hand),
      .hand_ready        (hand_ready),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_token_byte    (rsp_token_byte),
      .rsp_line_number   (rsp_line_number),
      .rsp_column_number (rsp_column_number),
      .rsp_error_code    (rsp_error_code),
      .rsp_last_result   (rsp_last_result)
   );

   // stream done always closes the results of its byte
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DONE |-> rsp_last_result)
      else $error("stream done not marked as last result");

   // only token bytes carry a data byte
   a_byte_only_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_BYTE |-> rsp_token_byte == 8'd0)
      else $error("non-byte result carries data");

   // only errors carry an error code
   a_code_only_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_ERROR |-> rsp_error_code == ERR_NONE)
      else $error("non-error result carries an error code");

endmodule
